FILE: design/dtmf_pkg.sv
// dtmf_pkg: shared types, constants and the keypad decode for the dtmf tone generator
// no dependencies; used by the sine rom and the top level
`default_nettype none

package dtmf_pkg;

    // defaults for the top-level parameters
    localparam int SAMPLE_RATE_HZ_DEF   = 44100;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int PHASE_BITS_DEF       = 32;

    // field widths
    localparam int KEY_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int AMP_W    = 15;
    localparam int COUNT_W  = 20;
    localparam int CFG_W    = 20;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_SAMPLES = 1'b1;

    localparam logic [AMP_W-1:0]   AMPLITUDE_RESET    = 15'd8192;
    localparam logic [COUNT_W-1:0] TONE_SAMPLES_RESET = 20'd4410;

    // pi/2 in q30, truncated
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam int unsigned LOW_GROUP_HZ  [4] = '{697, 770, 852, 941};
    localparam int unsigned HIGH_GROUP_HZ [4] = '{1209, 1336, 1477, 1633};

    typedef struct packed {
        logic [KEY_W-1:0] key_char;
        logic             start_req;
    } t_tone_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       key_valid;
        logic                       tone_last;
    } t_tone_out;

    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic [1:0] col;
    } t_key_info;

    // per-stage flags that ride along with the sample data
    typedef struct packed {
        logic sound;
        logic key_valid;
        logic tone_last;
    } t_flags;

    function automatic t_key_info keypad_decode(input logic [KEY_W-1:0] c);
        t_key_info k;
        k = '{valid: 1'b1, row: 2'd0, col: 2'd0};
        unique case (c)
            "1": begin k.row = 2'd0; k.col = 2'd0; end
            "2": begin k.row = 2'd0; k.col = 2'd1; end
            "3": begin k.row = 2'd0; k.col = 2'd2; end
            "A": begin k.row = 2'd0; k.col = 2'd3; end
            "4": begin k.row = 2'd1; k.col = 2'd0; end
            "5": begin k.row = 2'd1; k.col = 2'd1; end
            "6": begin k.row = 2'd1; k.col = 2'd2; end
            "B": begin k.row = 2'd1; k.col = 2'd3; end
            "7": begin k.row = 2'd2; k.col = 2'd0; end
            "8": begin k.row = 2'd2; k.col = 2'd1; end
            "9": begin k.row = 2'd2; k.col = 2'd2; end
            "C": begin k.row = 2'd2; k.col = 2'd3; end
            "*": begin k.row = 2'd3; k.col = 2'd0; end
            "0": begin k.row = 2'd3; k.col = 2'd1; end
            "#": begin k.row = 2'd3; k.col = 2'd2; end
            "D": begin k.row = 2'd3; k.col = 2'd3; end
            default: begin
                k.valid = 1'b0;
            end
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: design/dtmf_stream_if.sv
// dtmf_stream_if: valid/ready stream channel with a typed payload
// no dependencies; the payload type is set where the channel is instantiated
`default_nettype none

interface dtmf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/dtmf_sine_rom.sv
// dtmf_sine_rom: full-wave q1.15 sine table built at elaboration, two registered read ports
// depends on dtmf_pkg for the q30 half-pi constant and the sample width
`default_nettype none

module dtmf_sine_rom #(
    parameter int SINE_TABLE_DEPTH = dtmf_pkg::SINE_TABLE_DEPTH_DEF,
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH)
) (
    input  wire                                    i_clk,
    input  wire                                    i_en,
    input  wire  [ADDR_W-1:0]                      i_addr_lo,
    input  wire  [ADDR_W-1:0]                      i_addr_hi,
    output logic signed [dtmf_pkg::SAMPLE_W-1:0]   o_sin_lo,
    output logic signed [dtmf_pkg::SAMPLE_W-1:0]   o_sin_hi
);

    localparam logic [63:0] DEPTH64 = 64'(SINE_TABLE_DEPTH);

    logic signed [dtmf_pkg::SAMPLE_W-1:0] w_table [SINE_TABLE_DEPTH];

    // quarter-wave angle in q30, taylor series to x^15, every term truncated
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] T_Q  = 64'(4 * k);
        localparam logic [63:0] QUAD = T_Q / DEPTH64;
        localparam logic [63:0] R0   = T_Q % DEPTH64;
        localparam logic [63:0] R    = (QUAD == 64'd1 || QUAD == 64'd3) ? DEPTH64 - R0 : R0;
        localparam logic [63:0] A    = (R * dtmf_pkg::HALF_PI_Q30) / DEPTH64;
        localparam logic [63:0] A2   = (A * A) >> 30;
        localparam logic [63:0] T1   = ((A  * A2) >> 30) / 64'd6;
        localparam logic [63:0] T2   = ((T1 * A2) >> 30) / 64'd20;
        localparam logic [63:0] T3   = ((T2 * A2) >> 30) / 64'd42;
        localparam logic [63:0] T4   = ((T3 * A2) >> 30) / 64'd72;
        localparam logic [63:0] T5   = ((T4 * A2) >> 30) / 64'd110;
        localparam logic [63:0] T6   = ((T5 * A2) >> 30) / 64'd156;
        localparam logic [63:0] T7   = ((T6 * A2) >> 30) / 64'd210;
        localparam longint SUM_RAW = longint'(A) - longint'(T1) + longint'(T2)
                                   - longint'(T3) + longint'(T4) - longint'(T5)
                                   + longint'(T6) - longint'(T7);
        localparam longint SUM_POS = (SUM_RAW < 0) ? 64'sd0 : SUM_RAW;
        localparam longint MAG_R   = (SUM_POS + 64'sd16384) >>> 15;
        localparam longint MAG     = (MAG_R > 64'sd32767) ? 64'sd32767 : MAG_R;
        localparam longint VALUE   = (QUAD >= 64'd2) ? -MAG : MAG;

        assign w_table[k] = dtmf_pkg::SAMPLE_W'(VALUE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin_lo <= w_table[i_addr_lo];
            o_sin_hi <= w_table[i_addr_hi];
        end
    end

endmodule

`default_nettype wire

FILE: design/dtmf_tone_generator.sv
// dtmf_tone_generator: dds dual-tone generator, one sample word per input tick word
// depends on dtmf_pkg, dtmf_stream_if and dtmf_sine_rom
//
//   channel    dir   payload                          handshake
//   i_tick     in    key_char[7:0], start_req         valid/ready
//   o_sample   out   sample[15:0], key_valid, tone_last valid/ready
//   i_cfg_*    in    index 0 amplitude, 1 tone_samples write enable, no wait
//
// one tick word accepted per cycle unless every stage is full and the output stalled; its sample word
// reaches the output through four registers (phase-to-address multiply,
// registered sine rom read, amplitude multiply, round and saturate). i_rst_n is
// synchronous and active low; it clears the latched key, both phases, the sample
// count and the pipeline, and reloads the config registers. a stalled output
// backs up stage by stage; ticks are still taken while any stage holds a bubble.
`default_nettype none

module dtmf_tone_generator #(
    parameter int SAMPLE_RATE_HZ   = dtmf_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int SINE_TABLE_DEPTH = dtmf_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS       = dtmf_pkg::PHASE_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    dtmf_stream_if.sink                          i_tick,
    dtmf_stream_if.source                        o_sample,
    input  wire                                  i_cfg_we,
    input  wire  [dtmf_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire  [dtmf_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int PROD_W = PHASE_BITS + ADDR_W + 1;
    localparam int S_ADDR = 0;
    localparam int S_ROM  = 1;
    localparam int S_MUL  = 2;
    localparam int S_OUT  = 3;
    localparam int STAGES = 4;

    localparam logic [63:0] RATE64    = 64'(SAMPLE_RATE_HZ);
    localparam logic [63:0] HALF_RATE = RATE64 / 64'd2;
    localparam logic [PROD_W-1:0] DEPTH_C = PROD_W'(SINE_TABLE_DEPTH);

    localparam logic [PHASE_BITS-1:0] LOW_STEP [4] = '{
        PHASE_BITS'(((64'(dtmf_pkg::LOW_GROUP_HZ[0]) << PHASE_BITS) + HALF_RATE) / RATE64),
        PHASE_BITS'(((64'(dtmf_pkg::LOW_GROUP_HZ[1]) << PHASE_BITS) + HALF_RATE) / RATE64),
        PHASE_BITS'(((64'(dtmf_pkg::LOW_GROUP_HZ[2]) << PHASE_BITS) + HALF_RATE) / RATE64),
        PHASE_BITS'(((64'(dtmf_pkg::LOW_GROUP_HZ[3]) << PHASE_BITS) + HALF_RATE) / RATE64)
    };
    localparam logic [PHASE_BITS-1:0] HIGH_STEP [4] = '{
        PHASE_BITS'(((64'(dtmf_pkg::HIGH_GROUP_HZ[0]) << PHASE_BITS) + HALF_RATE) / RATE64),
        PHASE_BITS'(((64'(dtmf_pkg::HIGH_GROUP_HZ[1]) << PHASE_BITS) + HALF_RATE) / RATE64),
        PHASE_BITS'(((64'(dtmf_pkg::HIGH_GROUP_HZ[2]) << PHASE_BITS) + HALF_RATE) / RATE64),
        PHASE_BITS'(((64'(dtmf_pkg::HIGH_GROUP_HZ[3]) << PHASE_BITS) + HALF_RATE) / RATE64)
    };

    // config registers
    logic [dtmf_pkg::AMP_W-1:0]   r_amplitude;
    logic [dtmf_pkg::COUNT_W-1:0] r_tone_samples;

    // tone state
    logic [dtmf_pkg::KEY_W-1:0]   r_latched_key;
    logic [PHASE_BITS-1:0]        r_low_phase;
    logic [PHASE_BITS-1:0]        r_high_phase;
    logic [dtmf_pkg::COUNT_W-1:0] r_sample_count;

    // pipeline
    logic [STAGES-1:0]            r_valid;
    logic [STAGES-1:0]            w_move;
    logic [ADDR_W-1:0]            r_s1_addr_lo;
    logic [ADDR_W-1:0]            r_s1_addr_hi;
    dtmf_pkg::t_flags             r_s1_flags;
    dtmf_pkg::t_flags             r_s2_flags;
    dtmf_pkg::t_flags             r_s3_flags;
    logic signed [31:0]           r_s3_prod;
    dtmf_pkg::t_tone_out          r_out;

    logic signed [dtmf_pkg::SAMPLE_W-1:0] w_sin_lo;
    logic signed [dtmf_pkg::SAMPLE_W-1:0] w_sin_hi;

    logic                         w_acc;
    logic [dtmf_pkg::KEY_W-1:0]   w_key_eff;
    logic [PHASE_BITS-1:0]        w_low_eff;
    logic [PHASE_BITS-1:0]        w_high_eff;
    logic [dtmf_pkg::COUNT_W-1:0] w_count_eff;
    dtmf_pkg::t_key_info          w_key;
    logic                         w_active;
    dtmf_pkg::t_flags             w_flags;
    logic [PROD_W-1:0]            w_prod_lo;
    logic [PROD_W-1:0]            w_prod_hi;
    logic signed [16:0]           w_sin_sum;
    logic signed [32:0]           w_amp_prod;
    logic signed [31:0]           w_biased;
    logic signed [16:0]           w_rounded;
    logic signed [dtmf_pkg::SAMPLE_W-1:0] w_sat;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_move[S_OUT] = !r_valid[S_OUT] || o_sample.ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            w_move[i] = !r_valid[i] || w_move[i+1];
        end
    end

    assign i_tick.ready = w_move[S_ADDR];
    assign w_acc        = i_tick.valid && w_move[S_ADDR];

    // state as seen by this tick, after a start request
    always_comb begin
        if (i_tick.data.start_req) begin
            w_key_eff   = i_tick.data.key_char;
            w_low_eff   = '0;
            w_high_eff  = '0;
            w_count_eff = '0;
        end else begin
            w_key_eff   = r_latched_key;
            w_low_eff   = r_low_phase;
            w_high_eff  = r_high_phase;
            w_count_eff = r_sample_count;
        end
        w_key             = dtmf_pkg::keypad_decode(w_key_eff);
        w_active          = w_count_eff < r_tone_samples;
        w_flags.sound     = w_key.valid && w_active;
        w_flags.key_valid = w_key.valid;
        w_flags.tone_last = w_key.valid && w_active &&
                            ((21'(w_count_eff) + 21'd1) == 21'(r_tone_samples));
        // rom address = phase * depth >> phase bits
        w_prod_lo = PROD_W'(w_low_eff) * DEPTH_C;
        w_prod_hi = PROD_W'(w_high_eff) * DEPTH_C;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude    <= dtmf_pkg::AMPLITUDE_RESET;
            r_tone_samples <= dtmf_pkg::TONE_SAMPLES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dtmf_pkg::CFG_AMPLITUDE:    r_amplitude    <= i_cfg_data[dtmf_pkg::AMP_W-1:0];
                dtmf_pkg::CFG_TONE_SAMPLES: r_tone_samples <= i_cfg_data[dtmf_pkg::COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched_key  <= '0;
            r_low_phase    <= '0;
            r_high_phase   <= '0;
            r_sample_count <= '0;
        end else if (w_acc) begin
            r_latched_key <= w_key_eff;
            if (w_flags.sound) begin
                r_low_phase  <= w_low_eff + LOW_STEP[w_key.row];
                r_high_phase <= w_high_eff + HIGH_STEP[w_key.col];
            end else begin
                r_low_phase  <= w_low_eff;
                r_high_phase <= w_high_eff;
            end
            if (w_active) begin
                r_sample_count <= w_count_eff + 1'b1;
            end else begin
                r_sample_count <= w_count_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_move[S_ADDR]) r_valid[S_ADDR] <= i_tick.valid;
            if (w_move[S_ROM])  r_valid[S_ROM]  <= r_valid[S_ADDR];
            if (w_move[S_MUL])  r_valid[S_MUL]  <= r_valid[S_ROM];
            if (w_move[S_OUT])  r_valid[S_OUT]  <= r_valid[S_MUL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move[S_ADDR]) begin
            r_s1_addr_lo <= w_prod_lo[PHASE_BITS +: ADDR_W];
            r_s1_addr_hi <= w_prod_hi[PHASE_BITS +: ADDR_W];
            r_s1_flags   <= w_flags;
        end
        if (w_move[S_ROM]) begin
            r_s2_flags <= r_s1_flags;
        end
        if (w_move[S_MUL]) begin
            r_s3_flags <= r_s2_flags;
            r_s3_prod  <= r_s2_flags.sound ? 32'(w_amp_prod) : 32'sd0;
        end
        if (w_move[S_OUT]) begin
            r_out.sample    <= w_sat;
            r_out.key_valid <= r_s3_flags.key_valid;
            r_out.tone_last <= r_s3_flags.tone_last;
        end
    end

    dtmf_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk     (i_clk),
        .i_en      (w_move[S_ROM]),
        .i_addr_lo (r_s1_addr_lo),
        .i_addr_hi (r_s1_addr_hi),
        .o_sin_lo  (w_sin_lo),
        .o_sin_hi  (w_sin_hi)
    );

    always_comb begin
        w_sin_sum  = 17'(w_sin_lo) + 17'(w_sin_hi);
        w_amp_prod = 33'(signed'({1'b0, r_amplitude})) * 33'(w_sin_sum);
        // round half up, then clamp to 16 bits
        w_biased   = r_s3_prod + 32'sd16384;
        w_rounded  = w_biased[31:15];
        if (w_rounded > 17'sd32767) begin
            w_sat = 16'sh7fff;
        end else if (w_rounded < -17'sd32768) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_rounded[15:0];
        end
    end

    assign o_sample.valid = r_valid[S_OUT];
    assign o_sample.data  = r_out;

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick.ready |-> (&r_valid) && !o_sample.ready)
        else $error("input stalled with a bubble in the pipeline");

    a_start_resets_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_tick.data.start_req |=> r_sample_count <= 20'd1)
        else $error("start word did not restart the sample count");

    // a start word clears the phases even for an invalid key
    a_silent_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_tick.data.start_req && !w_key.valid
        |=> $stable(r_low_phase) && $stable(r_high_phase))
        else $error("phase moved on an invalid key");

    a_last_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[S_OUT] && r_out.tone_last |-> r_out.key_valid)
        else $error("tone_last without a valid key");
`endif

endmodule

`default_nettype wire
